// ----- rtl/core/lru_page_frame_tracker_unit_assert.svh -----
// Assertion macros for the LRU page frame tracker.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef LRU_PAGE_FRAME_TRACKER_UNIT_ASSERT_SVH
`define LRU_PAGE_FRAME_TRACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lpft_pkg.sv -----
package lpft_pkg;

    // Defaults for the top-level parameters
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF  = 32;

    // Width of the frames-in-use register and its reset value
    localparam int         CFG_W      = 4;
    localparam logic [3:0] FRAMES_RST = 4'd8;

    // Input transaction payload
    typedef struct packed {
        logic [15:0] page;
        logic        last_ref;
    } lpft_in_t;

    // Result transaction payload
    typedef struct packed {
        logic        fault;
        logic        evict_valid;
        logic [15:0] evicted_page;
        logic [31:0] fault_total;
        logic        done_res;
    } lpft_out_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic step;   // a reference is accepted this cycle
        logic flush;  // the reference ends its sequence
    } lpft_ctl_t;

endpackage

// ----- rtl/core/lru_page_frame_tracker_unit.sv -----
// Output: the result of a reference is registered and presented in the cycle after its acceptance.
// Throughput: one reference per cycle while results are taken; the row of frame cells
// compares combinationally and shifts as a reference is accepted, and a result register parts input from output.
// Reset: frame store empty, fault count zero, frames_in_use set to 8, no result pending.
// A reference marked last clears store and count once its result is formed.
module lru_page_frame_tracker_unit
    import lpft_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  lpft_in_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lpft_out_t        out_data
);

    localparam int CAP_W = $clog2(FRAME_COUNT + 1);

    logic [CFG_W-1:0]      frames_reg;
    logic [CAP_W-1:0]      cap;
    lpft_ctl_t             ctl;
    logic [PAGE_BITS-1:0]  ref_page;
    logic [FRAME_COUNT:0]  found;
    logic [PAGE_BITS-1:0]  cell_page  [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] cell_valid;
    logic [FRAME_COUNT-1:0] tail_valid;
    logic [PAGE_BITS-1:0]  tail_page  [FRAME_COUNT];
    logic                  evict;
    logic [PAGE_BITS-1:0]  victim;
    logic                  fault;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] cnt_upd;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lpft_out_t             out_data_reg;
    lpft_out_t             out_data_next;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RST;
        end
        else if (cfg_valid)
        begin
            frames_reg <= cfg_data;
        end
    end

    // Clamp the managed frame count to one up to the built frame count
    always_comb
    begin
        if (frames_reg == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (32'(frames_reg) > FRAME_COUNT)
        begin
            cap = CAP_W'(FRAME_COUNT);
        end
        else
        begin
            cap = CAP_W'(frames_reg);
        end
    end

    // Accept a reference whenever the result register is free or being drained
    assign in_ready   = !out_valid_reg || out_ready;
    assign ctl.step   = in_valid && in_ready;
    assign ctl.flush  = in_data.last_ref;
    assign ref_page   = PAGE_BITS'(in_data.page);
    assign found[0]   = 1'b0;

    // Build the row of frame cells, most recent first
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_COUNT; gi++)
        begin : g_cell
            logic [PAGE_BITS-1:0] prev_page;
            logic                 prev_valid;

            if (gi == 0)
            begin : g_head
                assign prev_page  = ref_page;
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_page  = cell_page[gi-1];
                assign prev_valid = cell_valid[gi-1];
            end

            lpft_cell #(
                .FRAME_COUNT (FRAME_COUNT),
                .PAGE_BITS   (PAGE_BITS),
                .IDX         (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .cap        (cap),
                .ref_page   (ref_page),
                .prev_page  (prev_page),
                .prev_valid (prev_valid),
                .found_in   (found[gi]),
                .found_out  (found[gi+1]),
                .page_q     (cell_page[gi]),
                .valid_q    (cell_valid[gi]),
                .tail_valid (tail_valid[gi]),
                .tail_page  (tail_page[gi])
            );
        end
    endgenerate

    // Collect the eviction candidate from the oldest managed cell
    always_comb
    begin
        victim = '0;
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            victim = victim | tail_page[i];
        end
    end

    assign fault = !found[FRAME_COUNT];
    assign evict = fault && (|tail_valid);

    // Advance the saturating fault count, clear it at the end of a sequence
    assign cnt_upd = (fault && (cnt_reg != '1)) ? cnt_reg + COUNT_BITS'(1) : cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.step)
        begin
            cnt_next = ctl.flush ? '0 : cnt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Form the result and hold it until taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (ctl.step)
        begin
            out_valid_next             = 1'b1;
            out_data_next.fault        = fault;
            out_data_next.evict_valid  = evict;
            out_data_next.evicted_page = evict ? 16'(victim) : 16'd0;
            out_data_next.fault_total  = 32'(cnt_upd);
            out_data_next.done_res     = in_data.last_ref;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Check eviction, victim reporting and store update
    `include "lru_page_frame_tracker_unit_assert.svh"

    `LPFT_ASSERT_NOW(a_evict_needs_fault, out_valid && out_data.evict_valid, out_data.fault, "eviction reported on a hit")
    `LPFT_ASSERT_NOW(a_victim_zero, out_valid && !out_data.evict_valid, out_data.evicted_page == 16'd0, "victim page not zero without eviction")
    `LPFT_ASSERT_NEXT(a_flush_empties, ctl.step && ctl.flush, cell_valid == '0, "frame store not empty after end of sequence")
    `LPFT_ASSERT_NEXT(a_head_filled, ctl.step && !ctl.flush, cell_valid[0], "most recent frame empty after a reference")

endmodule

// ----- rtl/core/lpft_cell.sv -----
module lpft_cell
    import lpft_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int IDX         = 0,
    localparam int CAP_W      = $clog2(FRAME_COUNT + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpft_ctl_t            ctl,
    input  logic [CAP_W-1:0]     cap,
    input  logic [PAGE_BITS-1:0] ref_page,
    input  logic [PAGE_BITS-1:0] prev_page,
    input  logic                 prev_valid,
    input  logic                 found_in,
    output logic                 found_out,
    output logic [PAGE_BITS-1:0] page_q,
    output logic                 valid_q,
    output logic                 tail_valid,
    output logic [PAGE_BITS-1:0] tail_page
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 in_range;
    logic                 is_tail;
    logic                 match;

    // Decide whether this position is managed and whether it holds the reference
    assign in_range  = cap > CAP_W'(IDX);
    assign is_tail   = cap == CAP_W'(IDX + 1);
    assign match     = in_range && valid_reg && (page_reg == ref_page);
    assign found_out = found_in | match;

    // Offer the entry as the eviction candidate when it is the oldest managed one
    assign tail_valid = is_tail && valid_reg;
    assign tail_page  = tail_valid ? page_reg : '0;

    assign page_q  = page_reg;
    assign valid_q = valid_reg;

    // Shift in from the younger neighbour up to the hit position, drop out of range, clear all at a sequence end
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        if (ctl.step)
        begin
            if (ctl.flush || !in_range)
            begin
                valid_next = 1'b0;
            end
            else if (!found_in)
            begin
                page_next  = prev_page;
                valid_next = prev_valid;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

// ----- test/lru_result_checker.sv -----
module lru_result_checker
    import lpft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  lpft_in_t         in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  lpft_out_t        out_data,
    output int               outstanding,
    output int               fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAMES    = FRAME_COUNT_DEF;
    localparam logic [31:0] FAULT_MAX = 32'hFFFF_FFFF;
    localparam int          PRINT_CAP = 100;

    // Shadow of the frame row, most recent first
    logic [15:0]      shadow_page [FRAMES];
    logic             shadow_used [FRAMES];
    logic [31:0]      faults_so_far;
    logic [CFG_W-1:0] frames_reg;
    lpft_out_t        expected_results [$];
    int               result_idx;

    task automatic clear_shadow();
        for (int i = 0; i < FRAMES; i++)
        begin
            shadow_page[i] = '0;
            shadow_used[i] = 1'b0;
        end
        faults_so_far = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < PRINT_CAP)
            $display("[%0t] result %0d: %s expected %0h got %0h",
                     $realtime, result_idx, what, want, got);
        fail_count++;
    endtask

    // Apply one page reference to the shadow row and form its result
    task automatic lru_lookup(input lpft_in_t req, output lpft_out_t res);
        int   cap;
        int   hit_at;
        logic hit;
        cap = int'(frames_reg);
        if (cap < 1)
            cap = 1;
        if (cap > FRAMES)
            cap = FRAMES;
        hit    = 1'b0;
        hit_at = 0;
        res    = '0;

        // drop entries beyond the managed count, unreported
        for (int i = cap; i < FRAMES; i++)
        begin
            shadow_page[i] = '0;
            shadow_used[i] = 1'b0;
        end

        for (int i = 0; i < cap; i++)
        begin
            if (!hit && shadow_used[i] && shadow_page[i] == req.page)
            begin
                hit    = 1'b1;
                hit_at = i;
            end
        end

        if (hit)
        begin
            for (int i = hit_at; i > 0; i--)
            begin
                shadow_page[i] = shadow_page[i-1];
                shadow_used[i] = shadow_used[i-1];
            end
        end
        else
        begin
            // full row: the least recent page leaves
            if (shadow_used[cap-1])
            begin
                res.evict_valid  = 1'b1;
                res.evicted_page = shadow_page[cap-1];
            end
            for (int i = cap - 1; i > 0; i--)
            begin
                shadow_page[i] = shadow_page[i-1];
                shadow_used[i] = shadow_used[i-1];
            end
            if (faults_so_far != FAULT_MAX)
                faults_so_far++;
        end
        shadow_page[0] = req.page;
        shadow_used[0] = 1'b1;

        res.fault       = !hit;
        res.fault_total = faults_so_far;
        res.done_res    = req.last_ref;

        // end of sequence: start the next one empty
        if (req.last_ref)
            clear_shadow();
    endtask

    // Watch the three channels; results first, then the new reference
    always @(posedge clk or negedge rst_n)
    begin
        lpft_out_t predicted;
        lpft_out_t oldest;
        if (!rst_n)
        begin
            clear_shadow();
            frames_reg = FRAMES_RST;
            expected_results.delete();
            result_idx  = 0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, fault_total", '0,
                                    out_data.fault_total);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_data.fault !== oldest.fault)
                        report_mismatch("fault", oldest.fault, out_data.fault);
                    if (out_data.evict_valid !== oldest.evict_valid)
                        report_mismatch("evict_valid", oldest.evict_valid,
                                        out_data.evict_valid);
                    if (out_data.evicted_page !== oldest.evicted_page)
                        report_mismatch("evicted_page", oldest.evicted_page,
                                        out_data.evicted_page);
                    if (out_data.fault_total !== oldest.fault_total)
                        report_mismatch("fault_total", oldest.fault_total,
                                        out_data.fault_total);
                    if (out_data.done_res !== oldest.done_res)
                        report_mismatch("done_res", oldest.done_res, out_data.done_res);
                end
                result_idx++;
            end

            // a reference taken with a frame count write still sees the old count
            if (in_valid && in_ready)
            begin
                lru_lookup(in_data, predicted);
                expected_results = {expected_results, predicted};
            end

            if (cfg_valid && cfg_ready)
                frames_reg = cfg_data;

            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpft_pkg::*;

    localparam int PHASE_REFS = 75;
    localparam int LONG_HOLD  = 60;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    lpft_in_t         in_data;
    logic             out_valid;
    logic             out_ready;
    lpft_out_t        out_data;
    int               outstanding;
    int               fail_count;

    int               refs_sent;
    bit               hold_off;
    bit               steady_send;
    bit               pressure_done;

    logic [CFG_W-1:0] phase_frames [14] = '{4'd0, 4'd2, 4'd15, 4'd1, 4'd9, 4'd5, 4'd3,
                                           4'd8, 4'd4, 4'd14, 4'd6, 4'd7, 4'd12, 4'd1};

    lru_page_frame_tracker_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    lru_result_checker lru_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 25);
    endfunction

    // Offer one reference and hold it until taken
    task automatic send_ref(input logic [15:0] page, input logic is_last);
        lpft_in_t item;
        int       gap;
        item.page     = page;
        item.last_ref = is_last;
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        refs_sent++;
        gap = (steady_send || hold_off) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Change the frame count once every result is back
    task automatic write_frames(input logic [CFG_W-1:0] frames);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        cfg_data  <= frames;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Working-set references with some scattered pages and random sequence ends
    task automatic random_phase(input int count);
        logic [15:0] base;
        logic [15:0] page;
        int          span;
        logic        is_last;
        base        = 16'($urandom_range(0, 65535));
        span        = $urandom_range(1, 12);
        steady_send = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 85)
                page = base + 16'($urandom_range(0, span - 1));
            else
                page = 16'($urandom_range(0, 65535));
            is_last = ($urandom_range(0, 11) == 0);
            send_ref(page, is_last);
            if (is_last)
            begin
                base = 16'($urandom_range(0, 65535));
                span = $urandom_range(1, 12);
            end
        end
        steady_send = 1'b0;
    endtask

    // Result side: random stalls, stretches without any, one long hold-off
    initial
    begin
        int n;
        out_ready     = 1'b0;
        hold_off      = 1'b0;
        pressure_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // start the hold-off while a reference is on offer
            if (!pressure_done && refs_sent >= 400 && in_valid)
            begin
                pressure_done = 1'b1;
                hold_off      = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 15)
                    n = $urandom_range(40, 150);
                else
                    n = $urandom_range(1, 8);
                repeat (n) @(posedge clk);
                n = idle_len();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int waited;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        refs_sent   = 0;
        steady_send = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count: extreme pages, fill, evictions, hits, sequence end
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        for (int p = 1; p <= 7; p++)
            send_ref(16'(p), 1'b0);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'h5555, 1'b1);
        send_ref(16'h0003, 1'b1);

        // single frame: once the frame is filled, every miss evicts
        write_frames(4'd1);
        send_ref(16'h0007, 1'b0);
        send_ref(16'hAAAA, 1'b1);

        // oversized count behaves as the full row
        write_frames(4'd15);
        for (int p = 0; p < 9; p++)
            send_ref(16'h0100 + 16'(p), 1'b0);

        // shrink mid-sequence: the dropped tail is not reported
        write_frames(4'd3);
        send_ref(16'h0101, 1'b1);

        foreach (phase_frames[i])
        begin
            write_frames(phase_frames[i]);
            random_phase(PHASE_REFS);
        end
        in_valid <= 1'b0;

        // drain
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 20000);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
